>>> design/rtspd_pkg.sv
// Shared types and constants for the interleaved RTSP deframer.
// Holds result kind codes, the front-to-back command type and the keyword tables.
// No dependencies.
package rtspd_pkg;

	localparam logic [2:0] KIND_RTP   = 3'd0;
	localparam logic [2:0] KIND_EMPTY = 3'd1;
	localparam logic [2:0] KIND_RTSP  = 3'd2;
	localparam logic [2:0] KIND_STALL = 3'd3;
	localparam logic [2:0] KIND_DISC  = 3'd4;

	localparam int Q_DEPTH = 4;
	localparam int Q_AW    = $clog2(Q_DEPTH);

	// At most one command per parsed byte; a prefix command expands into the eight
	// bytes of the status line start.
	typedef struct packed {
		logic       prefix;
		logic [2:0] kind;
		logic [7:0] data;
		logic       last;
		logic       clip;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic nonempty;
	} qstat_t;

	function automatic logic [7:0] kw_char(input logic [1:0] k, input logic [2:0] pos);
		logic [63:0] word;
		case (k)
			2'd0:    word = "RTSP/1.0";
			2'd1:    word = "ANNOUNCE";
			2'd2:    word = "REDIRECT";
			default: word = '0;
		endcase
		return word[8*(7-pos) +: 8];
	endfunction

	function automatic logic [7:0] hdr_char(input logic [3:0] pos);
		logic [119:0] word;
		word = "Content-Length:";
		if (pos == 4'd15)
			return 8'h00;
		return word[8*(14-pos) +: 8];
	endfunction

endpackage

>>> design/rtspd_fifo.sv
// Short command queue between the parser front and the result emitter.
// Depends on rtspd_pkg for the command type and queue depth.
module rtspd_fifo (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                wr_en,
	input  rtspd_pkg::cmd_t     wr_cmd,
	input  logic                rd_en,
	output rtspd_pkg::cmd_t     head,
	output rtspd_pkg::qstat_t   stat
);

	rtspd_pkg::cmd_t mem_q [rtspd_pkg::Q_DEPTH];
	logic [rtspd_pkg::Q_AW-1:0] wr_ptr_q;
	logic [rtspd_pkg::Q_AW-1:0] rd_ptr_q;
	logic [rtspd_pkg::Q_AW:0]   count_q;

	assign head          = mem_q[rd_ptr_q];
	assign stat.full     = (count_q == (rtspd_pkg::Q_AW+1)'(rtspd_pkg::Q_DEPTH));
	assign stat.nonempty = (count_q != '0);

	always_ff @(posedge clk) begin
		if (wr_en)
			mem_q[wr_ptr_q] <= wr_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (rd_en)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (wr_en && !rd_en)
				count_q <= count_q + 1'b1;
			else if (rd_en && !wr_en)
				count_q <= count_q - 1'b1;
		end
	end

endmodule

>>> design/rtspd_front.sv
// Byte parser: frame and keyword recognition, Content-Length parsing, command generation.
// Depends on rtspd_pkg for command type, kind codes and keyword tables.
module rtspd_front #(
	parameter int BODY_LENGTH_BITS = 20
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            accept,
	input  logic [7:0]      data_byte,
	input  logic            end_of_stream,
	input  logic            cfg_wr,
	input  logic [7:0]      cfg_data,
	output logic            cmd_valid,
	output rtspd_pkg::cmd_t cmd
);

	localparam int BL = BODY_LENGTH_BITS;

	localparam logic [3:0] PH_START   = 4'd0;
	localparam logic [3:0] PH_KEYWORD = 4'd1;
	localparam logic [3:0] PH_CHAN    = 4'd2;
	localparam logic [3:0] PH_LENHI   = 4'd3;
	localparam logic [3:0] PH_LENLO   = 4'd4;
	localparam logic [3:0] PH_PAYLOAD = 4'd5;
	localparam logic [3:0] PH_HEADERS = 4'd6;
	localparam logic [3:0] PH_BODY    = 4'd7;
	localparam logic [3:0] PH_STALL   = 4'd8;

	localparam logic [1:0] LP_SEARCH = 2'd0;
	localparam logic [1:0] LP_SKIP   = 2'd1;
	localparam logic [1:0] LP_NUMBER = 2'd2;
	localparam logic [1:0] LP_DONE   = 2'd3;

	localparam logic [BL-1:0] BODY_MAX = {BL{1'b1}};

	logic [7:0]    fwd_chan_q;
	logic [3:0]    phase_q, phase_n;
	logic [3:0]    pos_q, pos_n;
	logic [2:0]    cand_q, cand_n;
	logic          match_q, match_n;
	logic [BL-1:0] rem_q, rem_n;
	logic [2:0]    blp_q, blp_n;
	logic [3:0]    hnp_q, hnp_n;
	logic [1:0]    lpp_q, lpp_n;
	logic [BL-1:0] body_q, body_n;
	logic          clip_q, clip_n;

	// Values after the Content-Length step of a header byte.
	logic [3:0]    hnp_a;
	logic [1:0]    lpp_a;
	logic [BL-1:0] body_a;
	logic          clip_a;
	logic [BL-1:0] body_f;
	logic          clip_f;
	logic [BL+3:0] digit_sum;
	logic          is_digit;
	logic          is_blank;
	logic [2:0]    blp_a;
	logic [3:0]    eff_pos;
	logic [2:0]    kw_hit;
	logic [3:0]    kw_pos;
	logic [2:0]    kw_cand;
	logic [BL-1:0] rem_dec;

	assign is_digit = (data_byte >= "0") && (data_byte <= "9");
	assign is_blank = (data_byte == " ") || (data_byte == 8'h09) || (data_byte == 8'h0D) ||
		(data_byte == 8'h0A) || (data_byte == 8'h0B) || (data_byte == 8'h0C);
	assign digit_sum = ({4'b0, body_q} << 3) + ({4'b0, body_q} << 1) +
		{{(BL-4){1'b0}}, 4'(data_byte - "0")};
	assign rem_dec = (rem_q != '0) ? rem_q - 1'b1 : rem_q;

	always_comb begin
		hnp_a  = hnp_q;
		lpp_a  = lpp_q;
		body_a = body_q;
		clip_a = clip_q;
		case (lpp_q)
			LP_SEARCH: begin
				if (hnp_q != 4'd15 && data_byte == rtspd_pkg::hdr_char(hnp_q))
					hnp_a = hnp_q + 1'b1;
				else
					hnp_a = (data_byte == "C") ? 4'd1 : 4'd0;
				if (hnp_a == 4'd15) begin
					hnp_a = '0;
					lpp_a = LP_SKIP;
				end
			end
			LP_SKIP: begin
				hnp_a = '0;
				lpp_a = LP_NUMBER;
			end
			LP_NUMBER: begin
				if (is_digit) begin
					hnp_a = hnp_q | 4'd1;
					if (digit_sum[BL+3:BL] != '0) begin
						body_a = BODY_MAX;
						clip_a = 1'b1;
					end else begin
						body_a = digit_sum[BL-1:0];
					end
				end else if (!hnp_q[0] && is_blank) begin
					hnp_a = hnp_q;
				end else if (!hnp_q[0] && (data_byte == "+" || data_byte == "-")) begin
					hnp_a = hnp_q | ((data_byte == "-") ? 4'd3 : 4'd1);
				end else begin
					if (hnp_q[1] && body_q != '0) begin
						body_a = BODY_MAX;
						clip_a = 1'b1;
					end
					lpp_a = LP_DONE;
				end
			end
			default: begin
				lpp_a = lpp_q;
			end
		endcase
		// The blank line ends an unfinished number as well.
		body_f = body_a;
		clip_f = clip_a;
		if (lpp_a == LP_NUMBER && hnp_a[1] && body_a != '0) begin
			body_f = BODY_MAX;
			clip_f = 1'b1;
		end
		if (data_byte == 8'h0D)
			blp_a = (blp_q == 3'd2) ? 3'd3 : 3'd1;
		else if (data_byte == 8'h0A && (blp_q == 3'd1 || blp_q == 3'd3))
			blp_a = blp_q + 1'b1;
		else
			blp_a = '0;
	end

	always_comb begin
		eff_pos = (phase_q == PH_START) ? 4'd0 : pos_q;
		kw_cand = (phase_q == PH_START) ? 3'b111 : cand_q;
		for (int k = 0; k < 3; k++)
			kw_hit[k] = !eff_pos[3] &&
				(rtspd_pkg::kw_char(2'(k), eff_pos[2:0]) == data_byte);
		kw_pos = eff_pos + 1'b1;
	end

	always_comb begin
		phase_n   = phase_q;
		pos_n     = pos_q;
		cand_n    = cand_q;
		match_n   = match_q;
		rem_n     = rem_q;
		blp_n     = blp_q;
		hnp_n     = hnp_q;
		lpp_n     = lpp_q;
		body_n    = body_q;
		clip_n    = clip_q;
		cmd_valid = 1'b0;
		cmd       = '0;
		if (end_of_stream) begin
			phase_n   = PH_START;
			pos_n     = '0;
			cand_n    = 3'b111;
			match_n   = 1'b0;
			rem_n     = '0;
			blp_n     = '0;
			hnp_n     = '0;
			lpp_n     = LP_SEARCH;
			body_n    = '0;
			clip_n    = 1'b0;
			cmd_valid = 1'b1;
			cmd.kind  = rtspd_pkg::KIND_DISC;
		end else begin
			case (phase_q)
				PH_START, PH_KEYWORD: begin
					if (phase_q == PH_START && data_byte == "$") begin
						phase_n = PH_CHAN;
					end else begin
						cand_n = kw_cand & kw_hit;
						pos_n  = kw_pos;
						if (cand_n == '0) begin
							phase_n   = PH_STALL;
							cmd_valid = 1'b1;
							cmd.kind  = rtspd_pkg::KIND_STALL;
						end else if (kw_pos >= 4'd8) begin
							if (cand_n[0]) begin
								blp_n      = '0;
								hnp_n      = '0;
								lpp_n      = LP_SEARCH;
								body_n     = '0;
								clip_n     = 1'b0;
								phase_n    = PH_HEADERS;
								cmd_valid  = 1'b1;
								cmd.prefix = 1'b1;
								cmd.kind   = rtspd_pkg::KIND_RTSP;
							end else begin
								phase_n   = PH_STALL;
								cmd_valid = 1'b1;
								cmd.kind  = rtspd_pkg::KIND_STALL;
							end
						end else begin
							phase_n = PH_KEYWORD;
						end
					end
				end
				PH_CHAN: begin
					match_n = (data_byte == fwd_chan_q);
					phase_n = PH_LENHI;
				end
				PH_LENHI: begin
					rem_n   = {{(BL-16){1'b0}}, data_byte, 8'h00};
					phase_n = PH_LENLO;
				end
				PH_LENLO: begin
					rem_n = rem_q | {{(BL-8){1'b0}}, data_byte};
					if (rem_n == '0) begin
						cmd_valid = match_q;
						cmd.kind  = rtspd_pkg::KIND_EMPTY;
						phase_n   = PH_START;
					end else begin
						phase_n = PH_PAYLOAD;
					end
				end
				PH_PAYLOAD: begin
					rem_n     = rem_dec;
					cmd_valid = match_q;
					cmd.kind  = rtspd_pkg::KIND_RTP;
					cmd.data  = data_byte;
					cmd.last  = (rem_dec == '0);
					if (rem_dec == '0)
						phase_n = PH_START;
				end
				PH_HEADERS: begin
					hnp_n     = hnp_a;
					lpp_n     = lpp_a;
					body_n    = body_a;
					clip_n    = clip_a;
					blp_n     = blp_a;
					cmd_valid = 1'b1;
					cmd.kind  = rtspd_pkg::KIND_RTSP;
					cmd.data  = data_byte;
					cmd.clip  = clip_a;
					if (blp_a == 3'd4) begin
						blp_n    = '0;
						body_n   = body_f;
						clip_n   = clip_f;
						lpp_n    = LP_DONE;
						cmd.clip = clip_f;
						if (body_f == '0) begin
							cmd.last = 1'b1;
							phase_n  = PH_START;
						end else begin
							rem_n   = body_f;
							phase_n = PH_BODY;
						end
					end
				end
				PH_BODY: begin
					rem_n     = rem_dec;
					cmd_valid = 1'b1;
					cmd.kind  = rtspd_pkg::KIND_RTSP;
					cmd.data  = data_byte;
					cmd.last  = (rem_dec == '0);
					cmd.clip  = clip_q;
					if (rem_dec == '0)
						phase_n = PH_START;
				end
				PH_STALL: begin
					phase_n = PH_STALL;
				end
				default: begin
					phase_n = PH_START;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_chan_q <= '0;
		end else if (cfg_wr) begin
			fwd_chan_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_START;
			pos_q   <= '0;
			cand_q  <= 3'b111;
			match_q <= 1'b0;
			rem_q   <= '0;
			blp_q   <= '0;
			hnp_q   <= '0;
			lpp_q   <= LP_SEARCH;
			body_q  <= '0;
			clip_q  <= 1'b0;
		end else if (accept) begin
			phase_q <= phase_n;
			pos_q   <= pos_n;
			cand_q  <= cand_n;
			match_q <= match_n;
			rem_q   <= rem_n;
			blp_q   <= blp_n;
			hnp_q   <= hnp_n;
			lpp_q   <= lpp_n;
			body_q  <= body_n;
			clip_q  <= clip_n;
		end
	end

endmodule

>>> design/rtspd_back.sv
// Result emitter: expands queued commands into result items and holds the output register.
// Depends on rtspd_pkg for the command type, kind codes and keyword table.
module rtspd_back (
	input  logic              clk,
	input  logic              arst_n,
	input  rtspd_pkg::cmd_t   head,
	input  rtspd_pkg::qstat_t stat,
	output logic              deq,
	input  logic              pop,
	output logic              empty,
	output logic [2:0]        kind,
	output logic [7:0]        out_byte,
	output logic              last,
	output logic              length_clipped
);

	logic       out_valid_q;
	logic [2:0] kind_q;
	logic [7:0] byte_q;
	logic       last_q;
	logic       clip_q;
	logic [2:0] cnt_q;
	logic       emit;

	// A new result loads when the output register is free or being taken.
	assign emit = stat.nonempty && (!out_valid_q || pop);
	assign deq  = emit && (!head.prefix || cnt_q == 3'd7);

	assign empty          = !out_valid_q;
	assign kind           = kind_q;
	assign out_byte       = byte_q;
	assign last           = last_q;
	assign length_clipped = clip_q;

	always_ff @(posedge clk) begin
		if (emit) begin
			if (head.prefix) begin
				kind_q <= rtspd_pkg::KIND_RTSP;
				byte_q <= rtspd_pkg::kw_char(2'd0, cnt_q);
				last_q <= 1'b0;
				clip_q <= 1'b0;
			end else begin
				kind_q <= head.kind;
				byte_q <= head.data;
				last_q <= head.last;
				clip_q <= head.clip;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			cnt_q       <= '0;
		end else begin
			if (emit)
				out_valid_q <= 1'b1;
			else if (pop)
				out_valid_q <= 1'b0;
			if (emit && head.prefix)
				cnt_q <= cnt_q + 1'b1;
		end
	end

endmodule

>>> design/rtsp_interleaved_deframer.sv
// Top level of the interleaved RTP-over-TCP / RTSP deframer.
// Depends on rtspd_pkg, rtspd_front, rtspd_fifo and rtspd_back.

// The block takes one stream byte per cycle while full is low and returns result
// requests through a queue-style port. Every byte is parsed in the cycle it is
// accepted; the parser then places at most one command into a four-entry queue,
// and the emitter turns each command into one result per cycle while results are
// popped. The only command that takes longer is the recognized "RTSP/1.0" start,
// which the emitter plays out as eight results, so full can rise after such a
// start when bytes keep arriving. Otherwise full stays low as long as results are
// popped. Payload bytes are forwarded as they arrive, without buffering a whole
// frame. The RTP channel register may be written at any time the block is idle;
// cfg_ready is always high.
module rtsp_interleaved_deframer #(
	parameter int BODY_LENGTH_BITS = 20
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic [7:0] data_byte,
	input  logic       end_of_stream,
	output logic       empty,
	input  logic       pop,
	output logic [2:0] kind,
	output logic [7:0] out_byte,
	output logic       last,
	output logic       length_clipped,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [7:0] cfg_data
);

	rtspd_pkg::cmd_t   cmd;
	rtspd_pkg::cmd_t   head;
	rtspd_pkg::qstat_t stat;
	logic              cmd_valid;
	logic              accept;
	logic              deq;

	assign full      = stat.full;
	assign accept    = push && !stat.full;
	assign cfg_ready = 1'b1;

	rtspd_front #(
		.BODY_LENGTH_BITS(BODY_LENGTH_BITS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.data_byte    (data_byte),
		.end_of_stream(end_of_stream),
		.cfg_wr       (cfg_valid),
		.cfg_data     (cfg_data),
		.cmd_valid    (cmd_valid),
		.cmd          (cmd)
	);

	rtspd_fifo u_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.wr_en (accept && cmd_valid),
		.wr_cmd(cmd),
		.rd_en (deq),
		.head  (head),
		.stat  (stat)
	);

	rtspd_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head          (head),
		.stat          (stat),
		.deq           (deq),
		.pop           (pop),
		.empty         (empty),
		.kind          (kind),
		.out_byte      (out_byte),
		.last          (last),
		.length_clipped(length_clipped)
	);

endmodule

>>> design/rtspd_chk.sv
// Port-level checker for the deframer, attached to the top level by bind.
// Depends on rtspd_pkg for the result kind codes.
module rtspd_chk (
	input logic       clk,
	input logic       arst_n,
	input logic       push,
	input logic       full,
	input logic       empty,
	input logic       pop,
	input logic [2:0] kind,
	input logic [7:0] out_byte,
	input logic       last,
	input logic       length_clipped
);

	// A waiting result that is not taken stays on the ports unchanged.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(kind) && $stable(out_byte) &&
			$stable(last) && $stable(length_clipped)))
		else $error("waiting result changed before it was taken");

	// Marker results carry no byte, no end mark and no clip flag.
	a_marker: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && kind != rtspd_pkg::KIND_RTP && kind != rtspd_pkg::KIND_RTSP) |->
			(out_byte == 8'h00 && !last && !length_clipped))
		else $error("marker result carries payload fields");

	// The clip flag belongs to RTSP message bytes only.
	a_clip_rtp: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && kind == rtspd_pkg::KIND_RTP) |-> !length_clipped)
		else $error("clip flag set on an RTP payload byte");

	// Once the queue has room and nothing waits, a push cannot find it full next cycle
	// unless a request was accepted.
	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		(!full && empty && !push) |=> !full)
		else $error("queue became full without an accepted request");

endmodule

bind rtsp_interleaved_deframer rtspd_chk u_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.push          (push),
	.full          (full),
	.empty         (empty),
	.pop           (pop),
	.kind          (kind),
	.out_byte      (out_byte),
	.last          (last),
	.length_clipped(length_clipped)
);

>>> test/rtspd_result_checker.sv
// Result checker for the interleaved RTSP deframer: predicts every result from the
// accepted stream bytes and compares each popped result against the oldest prediction.
// Depends on rtspd_pkg for the result kind codes.
module rtspd_result_checker #(
	parameter int BODY_LENGTH_BITS = 20
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  logic       full,
	input  logic [7:0] data_byte,
	input  logic       end_of_stream,
	input  logic       empty,
	input  logic       pop,
	input  logic [2:0] kind,
	input  logic [7:0] out_byte,
	input  logic       last,
	input  logic       length_clipped,
	input  logic       cfg_valid,
	input  logic       cfg_ready,
	input  logic [7:0] cfg_data,
	output int         failures,
	output int         outstanding
);

	localparam longint unsigned BODY_MAX = (64'd1 << BODY_LENGTH_BITS) - 1;
	localparam logic [191:0] KEYWORDS = {"RTSP/1.0", "ANNOUNCE", "REDIRECT"};
	localparam logic [119:0] CLEN_NAME = "Content-Length:";

	typedef enum logic [3:0] {
		P_START, P_KEYWORD, P_CHAN, P_LENHI, P_LENLO, P_PAYLOAD, P_HEADERS, P_BODY, P_STALL
	} parse_phase_t;

	typedef enum logic [1:0] {CL_SEARCH, CL_SKIP, CL_NUMBER, CL_DONE} clen_phase_t;

	typedef struct packed {
		logic [2:0] kind;
		logic [7:0] data;
		logic       last;
		logic       clip;
	} deframer_result_t;

	deframer_result_t expected_results[$];
	deframer_result_t oldest;
	int               mismatch_count = 0;

	logic [7:0]        fwd_chan;
	parse_phase_t      phase;
	int unsigned       kw_pos;
	logic [2:0]        kw_alive;
	logic              chan_hit;
	longint unsigned   remaining;
	int unsigned       crlf_seen;
	int unsigned       name_pos;
	clen_phase_t       clen_phase;
	logic              num_started;
	logic              num_negative;
	longint unsigned   body_len;
	logic              clip;

	function automatic void add_result(input logic [2:0] k, input logic [7:0] d, input logic l);
		deframer_result_t r;
		r.kind = k;
		r.data = d;
		r.last = l;
		r.clip = (k == rtspd_pkg::KIND_RTSP) ? clip : 1'b0;
		expected_results.push_back(r);
	endfunction

	function automatic void clear_parser();
		phase = P_START;
		kw_pos = 0;
		kw_alive = 3'b111;
		chan_hit = 1'b0;
		remaining = 0;
		crlf_seen = 0;
		name_pos = 0;
		clen_phase = CL_SEARCH;
		num_started = 1'b0;
		num_negative = 1'b0;
		body_len = 0;
		clip = 1'b0;
	endfunction

	// A negative sign in front of a nonzero value saturates the body length.
	function automatic void close_number();
		if (num_negative && body_len != 0) begin
			body_len = BODY_MAX;
			clip = 1'b1;
		end
		clen_phase = CL_DONE;
	endfunction

	function automatic void predict_results(input logic [7:0] b, input logic eos);
		longint unsigned v;
		if (eos) begin
			clear_parser();
			add_result(rtspd_pkg::KIND_DISC, 8'h00, 1'b0);
			return;
		end
		if (phase == P_START) begin
			if (b == "$") begin
				phase = P_CHAN;
				return;
			end
			kw_pos = 0;
			kw_alive = 3'b111;
			phase = P_KEYWORD;
		end
		case (phase)
			P_KEYWORD: begin
				for (int k = 0; k < 3; k++)
					if (kw_pos >= 8 || KEYWORDS[64*(2-k) + 8*(7-kw_pos) +: 8] != b)
						kw_alive[k] = 1'b0;
				kw_pos++;
				if (kw_alive == 3'b000) begin
					phase = P_STALL;
					add_result(rtspd_pkg::KIND_STALL, 8'h00, 1'b0);
				end else if (kw_pos >= 8) begin
					if (kw_alive[0]) begin
						crlf_seen = 0;
						name_pos = 0;
						num_started = 1'b0;
						num_negative = 1'b0;
						clen_phase = CL_SEARCH;
						body_len = 0;
						clip = 1'b0;
						phase = P_HEADERS;
						for (int k = 0; k < 8; k++)
							add_result(rtspd_pkg::KIND_RTSP, KEYWORDS[128 + 8*(7-k) +: 8],
								1'b0);
					end else begin
						phase = P_STALL;
						add_result(rtspd_pkg::KIND_STALL, 8'h00, 1'b0);
					end
				end
			end
			P_CHAN: begin
				chan_hit = (b == fwd_chan);
				phase = P_LENHI;
			end
			P_LENHI: begin
				remaining = {48'd0, b, 8'h00};
				phase = P_LENLO;
			end
			P_LENLO: begin
				remaining = remaining | b;
				if (remaining == 0) begin
					if (chan_hit)
						add_result(rtspd_pkg::KIND_EMPTY, 8'h00, 1'b0);
					phase = P_START;
				end else begin
					phase = P_PAYLOAD;
				end
			end
			P_PAYLOAD: begin
				if (remaining != 0)
					remaining--;
				if (chan_hit)
					add_result(rtspd_pkg::KIND_RTP, b, remaining == 0);
				if (remaining == 0)
					phase = P_START;
			end
			P_HEADERS: begin
				case (clen_phase)
					CL_SEARCH: begin
						if (name_pos < 15 && b == CLEN_NAME[8*(14-name_pos) +: 8])
							name_pos++;
						else
							name_pos = (b == "C") ? 1 : 0;
						if (name_pos >= 15) begin
							name_pos = 0;
							clen_phase = CL_SKIP;
						end
					end
					CL_SKIP: begin
						num_started = 1'b0;
						num_negative = 1'b0;
						clen_phase = CL_NUMBER;
					end
					CL_NUMBER: begin
						if (b >= "0" && b <= "9") begin
							v = body_len * 10 + (b - "0");
							num_started = 1'b1;
							if (v > BODY_MAX) begin
								v = BODY_MAX;
								clip = 1'b1;
							end
							body_len = v;
						end else if (!num_started && (b == " " || b == 8'h09 || b == 8'h0D ||
								b == 8'h0A || b == 8'h0B || b == 8'h0C)) begin
							// Leading blanks are skipped.
						end else if (!num_started && (b == "+" || b == "-")) begin
							num_started = 1'b1;
							if (b == "-")
								num_negative = 1'b1;
						end else begin
							close_number();
						end
					end
					default: ;
				endcase
				if (b == 8'h0D)
					crlf_seen = (crlf_seen == 2) ? 3 : 1;
				else if (b == 8'h0A && (crlf_seen == 1 || crlf_seen == 3))
					crlf_seen++;
				else
					crlf_seen = 0;
				if (crlf_seen >= 4) begin
					crlf_seen = 0;
					if (clen_phase == CL_NUMBER)
						close_number();
					clen_phase = CL_DONE;
					if (body_len == 0) begin
						add_result(rtspd_pkg::KIND_RTSP, b, 1'b1);
						phase = P_START;
					end else begin
						add_result(rtspd_pkg::KIND_RTSP, b, 1'b0);
						remaining = body_len;
						phase = P_BODY;
					end
				end else begin
					add_result(rtspd_pkg::KIND_RTSP, b, 1'b0);
				end
			end
			P_BODY: begin
				if (remaining != 0)
					remaining--;
				add_result(rtspd_pkg::KIND_RTSP, b, remaining == 0);
				if (remaining == 0)
					phase = P_START;
			end
			P_STALL: ;
			default: phase = P_START;
		endcase
	endfunction

	// Results popped at an edge come from bytes taken at earlier edges, so the
	// comparison runs before this edge's byte is predicted.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_parser();
			fwd_chan = 8'h00;
			expected_results.delete();
			outstanding <= 0;
			failures <= 0;
		end else begin
			if (pop && !empty) begin
				if (expected_results.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("unexpected result: kind %0d byte %02h last %0b clip %0b",
							kind, out_byte, last, length_clipped);
				end else begin
					oldest = expected_results.pop_front();
					if ({kind, out_byte, last, length_clipped} !== oldest) begin
						mismatch_count++;
						if (mismatch_count <= 10)
							$display({"mismatch: expected kind %0d byte %02h last %0b clip %0b,",
								" got kind %0d byte %02h last %0b clip %0b"},
								oldest.kind, oldest.data, oldest.last, oldest.clip,
								kind, out_byte, last, length_clipped);
					end
				end
			end
			if (cfg_valid && cfg_ready)
				fwd_chan = cfg_data;
			if (push && !full)
				predict_results(data_byte, end_of_stream);
			outstanding <= expected_results.size();
			failures <= mismatch_count;
		end
	end

endmodule

>>> test/tb.sv
// Testbench top for the interleaved RTSP deframer: drives framed and text streams,
// idles both sides at random and gives the verdict.
// Depends on rtsp_interleaved_deframer and rtspd_result_checker.
module tb;

	localparam int BODY_BITS   = 20;
	localparam int PHASE_ITEMS = 45;
	localparam int SETTLE      = 8;
	localparam int IDLE_LIMIT  = 3000;

	localparam int RX_STREAM = 0;
	localparam int RX_COIN   = 1;
	localparam int RX_THIRDS = 2;
	localparam int RX_BURSTY = 3;

	logic       clk;
	logic       arst_n = 1'b0;
	logic       push = 1'b0;
	logic       full;
	logic [7:0] data_byte = 8'h00;
	logic       end_of_stream = 1'b0;
	logic       empty;
	logic       pop = 1'b0;
	logic [2:0] kind;
	logic [7:0] out_byte;
	logic       last;
	logic       length_clipped;
	logic       cfg_valid = 1'b0;
	logic       cfg_ready;
	logic [7:0] cfg_data = 8'h00;

	int          failures;
	int          outstanding;
	int          idle_cycles = 0;
	int unsigned items_sent = 0;
	int          burst_left = 0;
	int unsigned msg_form;
	int unsigned stall_form;
	int          rx_mode = RX_STREAM;
	int          rx_mode_left = 0;
	int          rx_stall_left = 0;
	int unsigned rx_tick = 0;

	rtsp_interleaved_deframer #(
		.BODY_LENGTH_BITS(BODY_BITS)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.data_byte(data_byte),
		.end_of_stream(end_of_stream),
		.empty(empty),
		.pop(pop),
		.kind(kind),
		.out_byte(out_byte),
		.last(last),
		.length_clipped(length_clipped),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	rtspd_result_checker #(
		.BODY_LENGTH_BITS(BODY_BITS)
	) u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.data_byte(data_byte),
		.end_of_stream(end_of_stream),
		.empty(empty),
		.pop(pop),
		.kind(kind),
		.out_byte(out_byte),
		.last(last),
		.length_clipped(length_clipped),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.failures(failures),
		.outstanding(outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// The receiver switches between steady popping, coin flips, periodic popping
	// and long stalls with single pops.
	always @(posedge clk) begin
		if (rx_mode_left == 0) begin
			rx_mode <= $urandom_range(RX_STREAM, RX_BURSTY);
			rx_mode_left <= $urandom_range(20, 80);
		end else begin
			rx_mode_left <= rx_mode_left - 1;
		end
		rx_tick <= rx_tick + 1;
		case (rx_mode)
			RX_STREAM: pop <= 1'b1;
			RX_COIN:   pop <= 1'($urandom_range(0, 1));
			RX_THIRDS: pop <= (rx_tick % 3 == 0);
			default: begin
				if (rx_stall_left == 0) begin
					pop <= 1'b1;
					rx_stall_left <= $urandom_range(1, 12);
				end else begin
					pop <= 1'b0;
					rx_stall_left <= rx_stall_left - 1;
				end
			end
		endcase
	end

	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
	end

	initial begin : watchdog
		while (idle_cycles < IDLE_LIMIT)
			@(posedge clk);
		$display("TB_ERROR");
		$finish;
	end

	// Sends one stream byte; bursts of random length are separated by random gaps.
	task automatic send_item(input logic [7:0] b, input logic eos, input bit counted);
		int gap;
		if (burst_left <= 0) begin
			case ($urandom_range(0, 9))
				0, 1, 2: gap = 0;
				3:       gap = $urandom_range(10, 30);
				default: gap = $urandom_range(1, 5);
			endcase
			if (gap != 0) begin
				push <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		push <= 1'b1;
		data_byte <= b;
		end_of_stream <= eos;
		do @(posedge clk); while (full);
		burst_left--;
		if (counted)
			items_sent++;
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_item(s[i], 1'b0, 1'b1);
	endtask

	task automatic send_frame(input logic [7:0] ch, input logic [15:0] flen, input int nsend);
		send_item("$", 1'b0, 1'b1);
		send_item(ch, 1'b0, 1'b1);
		send_item(flen[15:8], 1'b0, 1'b1);
		send_item(flen[7:0], 1'b0, 1'b1);
		repeat (nsend) send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
	endtask

	task automatic wait_results_drained();
		push <= 1'b0;
		burst_left = 0;
		do @(posedge clk); while (outstanding != 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_channel(input logic [7:0] ch);
		cfg_valid <= 1'b1;
		cfg_data <= ch;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	// Mostly well-formed frames and messages with random content; the rest are
	// stalling starts, cut frames and noise, each closed by an end of stream.
	task automatic send_random_sequence(input logic [7:0] chan);
		int              sel;
		int              n;
		int              body;
		bit              open_ended;
		string           clen_line;
		string           kw;
		logic [7:0]      other;
		other = chan ^ (8'h01 << $urandom_range(0, 7));
		sel = $urandom_range(0, 99);
		if (sel < 40) begin
			case ($urandom_range(0, 2))
				0:       send_text("RTSP/1.0 200 OK\r\n");
				1:       send_text("RTSP/1.0\r\n");
				default: send_text("RTSP/1.0 C\r\n");
			endcase
			body = 0;
			open_ended = 1'b0;
			case (msg_form % 7)
				0: clen_line = "";
				1: begin
					body = $urandom_range(1, 4);
					clen_line = $sformatf("Content-Length: %0d\r\n", body);
				end
				2: begin
					body = $urandom_range(0, 4);
					clen_line = $sformatf("Content-Length:x\t +%0d\r\n", body);
				end
				3: begin
					// Values at and beyond the largest body length.
					open_ended = 1'b1;
					case ($urandom_range(0, 2))
						0:       clen_line = "Content-Length: 1048575\r\n";
						1:       clen_line = "Content-Length: 1048576\r\n";
						default: clen_line = "Content-Length:99999999999\r\n";
					endcase
				end
				4: begin
					open_ended = 1'b1;
					clen_line = $sformatf("Content-Length: -%0d\r\n", $urandom_range(1, 9));
				end
				5: clen_line = $urandom_range(0, 1) ? "Content-Length: -0\r\n"
					: "Content-Length: \r\n";
				default: begin
					// Only the first header counts; a doubled C restarts the name match.
					body = $urandom_range(1, 3);
					clen_line = $sformatf("CContent-Length: %0dx\r\nContent-Length: 9\r\n", body);
				end
			endcase
			msg_form++;
			send_text({clen_line, "\r\n"});
			if (open_ended) begin
				repeat ($urandom_range(0, 3)) send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
				send_item(8'($urandom_range(0, 255)), 1'b1, 1'b1);
			end else begin
				repeat (body) send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
			end
		end else if (sel < 65) begin
			n = $urandom_range(0, 5);
			send_frame(chan, 16'(n), n);
		end else if (sel < 75) begin
			n = $urandom_range(0, 3);
			send_frame(other, 16'(n), n);
		end else if (sel < 85) begin
			case (stall_form % 4)
				0: send_text("ANNOUNCE");
				1: send_text("REDIRECT");
				2: begin
					case ($urandom_range(0, 2))
						0:       kw = "RTSP/1.0";
						1:       kw = "ANNOUNCE";
						default: kw = "REDIRECT";
					endcase
					send_text(kw.substr(0, $urandom_range(0, 6)));
					send_item(8'($urandom_range("a", "z")), 1'b0, 1'b1);
				end
				default: send_item(8'($urandom_range(0, 1) ? $urandom_range("a", "z")
					: $urandom_range(8'h80, 8'hFF)), 1'b0, 1'b1);
			endcase
			stall_form++;
			// These bytes are ignored while the parser is stalled.
			repeat ($urandom_range(0, 2)) send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
			send_item(8'($urandom_range(0, 255)), 1'b1, 1'b1);
		end else if (sel < 90) begin
			send_frame(sel[0] ? chan : other, 16'($urandom_range(16'h0100, 16'hFFFF)),
				$urandom_range(0, 3));
			send_item(8'($urandom_range(0, 255)), 1'b1, 1'b1);
		end else begin
			repeat ($urandom_range(1, 4))
				send_item(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0, 1'b1);
			send_item(8'($urandom_range(0, 255)), 1'b1, 1'b1);
		end
	endtask

	initial begin
		logic [7:0]  chan;
		int unsigned phase_start;
		msg_form = $urandom_range(0, 6);
		stall_form = $urandom_range(0, 3);
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		chan = 8'h00;
		write_channel(chan);

		// Directed part: disconnect, empty packet, payload extremes, a foreign
		// channel, a frame cut by end of stream and an unknown start.
		send_item(8'hFF, 1'b1, 1'b1);
		send_frame(chan, 16'h0000, 0);
		send_frame(chan, 16'h0002, 0);
		send_item(8'h00, 1'b0, 1'b1);
		send_item(8'hFF, 1'b0, 1'b1);
		send_frame(chan ^ 8'h80, 16'h0001, 1);
		send_frame(chan, 16'hFFFF, 1);
		send_item(8'h00, 1'b1, 1'b1);
		send_item("Q", 1'b0, 1'b1);
		send_item("$", 1'b0, 1'b0);
		send_item(8'h00, 1'b1, 1'b1);

		for (int ph = 0; ph < 4; ph++) begin
			if (ph != 0) begin
				wait_results_drained();
				case (ph)
					1:       chan = 8'hFF;
					2:       chan = 8'($urandom_range(1, 254));
					default: chan = "$";
				endcase
				write_channel(chan);
			end
			phase_start = items_sent;
			while (items_sent - phase_start < PHASE_ITEMS)
				send_random_sequence(chan);
		end

		wait_results_drained();
		if (failures == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
